FILE: rtl/tcdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcdr_pkg;

    localparam int MAX_PAYLOAD = 512;
    // Byte position saturates at MAX_PAYLOAD + 4.
    localparam int POS_W = $clog2(MAX_PAYLOAD + 5);
    localparam int PCNT_W = 10;
    localparam int BLK_W = 16;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB = 8'h80;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Everything one accepted byte causes: an optional forwarded payload byte
    // followed by an optional end-of-packet verdict.
    typedef struct packed {
        logic               has_fwd;
        logic [7:0]         fwd_byte;
        logic               has_verdict;
        logic               frame_ok;
        logic               crc_ok;
        logic               commit;
        logic [BLK_W-1:0]   ack_block;
        logic               transfer_done;
        logic [PCNT_W-1:0]  payload_count;
    } job_t;

endpackage

`default_nettype wire

FILE: rtl/tcdr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcdr_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic [7:0]          data_byte,
    input  wire logic                end_of_packet,
    input  wire logic                q_full,
    output logic                     enq,
    output tcdr_pkg::job_t           job
);

    logic [tcdr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                  crc_reg, crc_next;
    logic [7:0]                  held_reg, held_next;
    logic [tcdr_pkg::BLK_W-1:0]  blk_reg, blk_next;
    logic [tcdr_pkg::BLK_W-1:0]  last_blk_reg, last_blk_next;
    logic                        over_reg, over_next;

    logic                        accept;
    logic                        fwd;
    logic [7:0]                  crc_upd;
    logic                        fok;
    logic                        cok;
    logic                        com;
    logic                        done;
    logic [tcdr_pkg::POS_W-1:0]  cnt_full;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((c & tcdr_pkg::CRC_MSB) != 8'd0)
            begin
                c = {c[6:0], 1'b0} ^ tcdr_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign accept  = push && !q_full;
    assign fwd     = (pos_reg >= tcdr_pkg::POS_W'(5)) && !over_reg;
    assign crc_upd = fwd ? crc8_update(crc_reg, held_reg) : crc_reg;
    assign fok     = (pos_reg >= tcdr_pkg::POS_W'(4)) && !over_reg;
    assign cnt_full = pos_reg - tcdr_pkg::POS_W'(4);
    assign cok     = fok && (crc_upd == data_byte);
    assign com     = cok && (blk_reg == last_blk_reg + tcdr_pkg::BLK_W'(1));
    assign done    = cok && (cnt_full < tcdr_pkg::POS_W'(tcdr_pkg::MAX_PAYLOAD));

    // Only the final byte of a packet or a forwarded byte produces a result.
    assign enq = accept && (fwd || end_of_packet);

    always_comb
    begin
        job = '0;
        job.has_fwd     = fwd;
        job.fwd_byte    = held_reg;
        job.has_verdict = end_of_packet;
        if (end_of_packet)
        begin
            job.frame_ok      = fok;
            job.crc_ok        = cok;
            job.commit        = com;
            job.ack_block     = cok ? blk_reg : '0;
            job.transfer_done = done;
            job.payload_count = fok ? tcdr_pkg::PCNT_W'(cnt_full) : '0;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        held_next     = held_reg;
        blk_next      = blk_reg;
        last_blk_next = last_blk_reg;
        over_next     = over_reg;
        if (accept)
        begin
            if (!end_of_packet)
            begin
                if (pos_reg == tcdr_pkg::POS_W'(2))
                begin
                    blk_next = {data_byte, blk_reg[7:0]};
                end
                else if (pos_reg == tcdr_pkg::POS_W'(3))
                begin
                    blk_next = {blk_reg[15:8], data_byte};
                end
                crc_next = crc_upd;
                if (pos_reg >= tcdr_pkg::POS_W'(tcdr_pkg::MAX_PAYLOAD + 4))
                begin
                    over_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + tcdr_pkg::POS_W'(1);
                end
                held_next = data_byte;
            end
            else
            begin
                if (com)
                begin
                    last_blk_next = blk_reg;
                end
                // The transfer has ended, so the next one starts from block zero.
                if (done)
                begin
                    last_blk_next = '0;
                end
                pos_next  = '0;
                crc_next  = '0;
                held_next = '0;
                blk_next  = '0;
                over_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            held_reg     <= '0;
            blk_reg      <= '0;
            last_blk_reg <= '0;
            over_reg     <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            held_reg     <= held_next;
            blk_reg      <= blk_next;
            last_blk_reg <= last_blk_next;
            over_reg     <= over_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcdr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tcdr_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            enq,
    input  wire tcdr_pkg::job_t  enq_job,
    input  wire logic            deq,
    output logic                 q_full,
    output logic                 q_empty,
    output tcdr_pkg::job_t       head_job
);

    tcdr_pkg::job_t                 slots_reg [tcdr_pkg::QDEPTH];
    logic [tcdr_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tcdr_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tcdr_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_enq;
    logic                           do_deq;

    assign q_full   = (count_reg == tcdr_pkg::QCNT_W'(tcdr_pkg::QDEPTH));
    assign q_empty  = (count_reg == '0);
    assign head_job = slots_reg[rd_ptr_reg];
    assign do_enq   = enq && !q_full;
    assign do_deq   = deq && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_enq ? wr_ptr_reg + tcdr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_deq ? rd_ptr_reg + tcdr_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq && !do_deq)
        begin
            count_next = count_reg + tcdr_pkg::QCNT_W'(1);
        end
        else if (!do_enq && do_deq)
        begin
            count_next = count_reg - tcdr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            slots_reg[wr_ptr_reg] <= enq_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcdr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcdr_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire tcdr_pkg::job_t                head_job,
    input  wire logic                          pop,
    output logic                               deq,
    output logic                               kind,
    output logic [7:0]                         payload_byte,
    output logic                               frame_ok,
    output logic                               crc_ok,
    output logic                               commit,
    output logic                               send_ack,
    output logic [tcdr_pkg::BLK_W-1:0]         ack_block,
    output logic                               transfer_done,
    output logic [tcdr_pkg::PCNT_W-1:0]        payload_count,
    output logic                               last_of_run
);

    // Set once the forwarded byte of the head entry has been taken and its
    // verdict is still to go.
    logic   phase_reg, phase_next;
    logic   show_fwd;
    logic   taken;

    assign show_fwd = head_job.has_fwd && !phase_reg;
    assign taken    = pop && !q_empty;
    assign deq      = taken && !(show_fwd && head_job.has_verdict);

    assign kind          = !show_fwd;
    assign payload_byte  = show_fwd ? head_job.fwd_byte : 8'd0;
    assign frame_ok      = !show_fwd && head_job.frame_ok;
    assign crc_ok        = !show_fwd && head_job.crc_ok;
    assign commit        = !show_fwd && head_job.commit;
    assign send_ack      = !show_fwd && head_job.crc_ok;
    assign ack_block     = show_fwd ? '0 : head_job.ack_block;
    assign transfer_done = !show_fwd && head_job.transfer_done;
    assign payload_count = show_fwd ? '0 : head_job.payload_count;
    assign last_of_run   = show_fwd ? !head_job.has_verdict : 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        if (taken)
        begin
            phase_next = show_fwd && head_job.has_verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tftp_crc_data_receiver.sv
// Receive side of a block-numbered DATA transfer with a CRC-8 trailer. One packet byte
// is taken per cycle (push while full is low), with end_of_packet on the final CRC byte.
// Payload bytes come out one byte late as kind 0 results; the final byte gives a kind 1
// verdict with frame, CRC, commit, ACK and end-of-transfer flags. A beat in is classified
// combinationally by the front end and queued; each result takes one pop beat out, so a
// final byte that also releases a payload byte is popped as two results. A four-entry
// queue between front and back end absorbs output stalls.
`timescale 1ns / 1ps
`default_nettype none

module tftp_crc_data_receiver
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          end_of_packet,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               kind,
    output logic [7:0]                         payload_byte,
    output logic                               frame_ok,
    output logic                               crc_ok,
    output logic                               commit,
    output logic                               send_ack,
    output logic [tcdr_pkg::BLK_W-1:0]         ack_block,
    output logic                               transfer_done,
    output logic [tcdr_pkg::PCNT_W-1:0]        payload_count,
    output logic                               last_of_run
);

    logic            enq;
    logic            deq;
    logic            q_full;
    logic            q_empty;
    tcdr_pkg::job_t  enq_job;
    tcdr_pkg::job_t  head_job;

    assign full  = q_full;
    assign empty = q_empty;

    tcdr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .data_byte     (data_byte),
        .end_of_packet (end_of_packet),
        .q_full        (q_full),
        .enq           (enq),
        .job           (enq_job)
    );

    tcdr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_job  (enq_job),
        .deq      (deq),
        .q_full   (q_full),
        .q_empty  (q_empty),
        .head_job (head_job)
    );

    tcdr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head_job      (head_job),
        .pop           (pop),
        .deq           (deq),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .frame_ok      (frame_ok),
        .crc_ok        (crc_ok),
        .commit        (commit),
        .send_ack      (send_ack),
        .ack_block     (ack_block),
        .transfer_done (transfer_done),
        .payload_count (payload_count),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire
